>>> rtl/assert_macros.svh
// Assertion macros shared by the audio serial FIFO port RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Concurrent assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

>>> rtl/asfp_pkg.sv
// Package: shared types and constants of the audio serial FIFO port.
package asfp_pkg;
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TX    = 2'd2;
  localparam logic [1:0] REQ_RX    = 2'd3;

  localparam logic [31:0] ID_RESET  = 32'h0302_0002;
  localparam logic [31:0] CAP_RESET = 32'd329473;

  localparam logic [9:0] A_ID    = 10'h000;
  localparam logic [9:0] A_CAP   = 10'h004;
  localparam logic [9:0] A_TCSR  = 10'h008;
  localparam logic [9:0] A_TDATA = 10'h020;
  localparam logic [9:0] A_TPTR  = 10'h040;
  localparam logic [9:0] A_RCSR  = 10'h088;
  localparam logic [9:0] A_RDATA = 10'h0a0;
  localparam logic [9:0] A_RPTR  = 10'h0c0;

  localparam int B_EN   = 31;
  localparam int B_FR   = 25;
  localparam int B_SR   = 24;
  localparam int B_FEF  = 18;
  localparam int B_FWF  = 17;
  localparam int B_FRF  = 16;
  localparam int B_FEIE = 10;
  localparam int B_FWIE = 9;
  localparam int B_FRIE = 8;
  localparam int B_DMA  = 0;
  localparam logic [31:0] M_W1C = 32'h001c_0000;
  localparam logic [31:0] M_RO  = 32'h0003_0000;
  localparam logic [31:0] TCSR_RESET = 32'h0003_0000;

  localparam logic [1:0] CFG_ID  = 2'd0;
  localparam logic [1:0] CFG_CAP = 2'd1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic exec;    // evaluate item, update state, issue reads
    logic finish;  // finish step: form result from read data
  } asfp_cmd_t;
endpackage

>>> rtl/asfp_ctrl.sv
// Controller: sequencer of the exec and finish steps for one item.
module asfp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output asfp_pkg::asfp_cmd_t cmd_o
);
  import asfp_pkg::*;
  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_FIN  = 1'b1;
  logic [0:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = (state_q == S_FIN);
  assign cmd_o.exec = start_i && (state_q == S_IDLE);
  assign cmd_o.finish = (state_q == S_FIN);

  `include "assert_macros.svh"
  `ASSERT_CLK(a_fin_follows, cmd_o.exec |=> cmd_o.finish, "finish must follow exec")
  `ASSERT_ALWAYS(a_excl, !(cmd_o.exec && cmd_o.finish), "exec and finish overlap")
  `ASSERT_CLK(a_no_exec_busy, busy_o |-> !cmd_o.exec, "word taken while busy")
endmodule

>>> rtl/asfp_dp.sv
// Datapath: register file, FIFOs, flags, interrupt and result registers.
module asfp_dp #(
  parameter int FIFO_DEPTH = 128,
  parameter int REG_WORDS  = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asfp_pkg::asfp_cmd_t cmd_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [1:0]          req_type_i,
  input  logic [9:0]          address_i,
  input  logic [31:0]         write_data_i,
  output logic                done_o,
  output logic [31:0]         read_data_o,
  output logic                irq_level_o,
  output logic                dma_request_o,
  output logic                tx_word_valid_o,
  output logic [31:0]         tx_word_o
);
  import asfp_pkg::*;
  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LW = $clog2(FIFO_DEPTH + 1);
  localparam int RW = $clog2(REG_WORDS);
  localparam logic [LW-1:0] FULL = LW'(FIFO_DEPTH);
  localparam logic [PW-1:0] PLAST = PW'(FIFO_DEPTH - 1);
  localparam logic [1:0] K_REG = 2'd0;
  localparam logic [1:0] K_TX  = 2'd1;
  localparam logic [1:0] K_RX  = 2'd2;

  logic [31:0] id_q, cap_q;
  logic [31:0] regs_q [REG_WORDS];  // words at fixed indexes are flops
  logic [31:0] tx_mem [FIFO_DEPTH];
  logic [15:0] rx_mem [FIFO_DEPTH];
  logic [PW-1:0] trp_q, twp_q, rrp_q, rwp_q;
  logic [LW-1:0] tlv_q, rlv_q;
  logic [7:0] saw_q;
  logic irq_q;

  // Pending result pieces held between exec and finish.
  logic [1:0] kind_q;   // register value, tx pop or rx pop from memory
  logic [31:0] rd_q;
  logic dma_q, tv_q, irq_rslt_q;
  logic [31:0] txrd_q;
  logic [15:0] rxrd_q;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PLAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic side_irq(input logic [31:0] c);
    return (c[B_FRF] && c[B_FRIE]) || (c[B_FWF] && c[B_FWIE]) ||
           (c[B_FEF] && c[B_FEIE]);
  endfunction

  logic [31:0] tcsr, rcsr, tcr1, rcr1;
  assign tcsr = regs_q[2];
  assign tcr1 = regs_q[3];
  assign rcsr = regs_q[34];
  assign rcr1 = regs_q[35];

  // Next-state logic of one item.
  logic [31:0] tcsr_n, rcsr_n, rd_n, wr_reg_v;
  logic [PW-1:0] trp_n, twp_n, rrp_n, rwp_n;
  logic [LW-1:0] tlv_n, rlv_n;
  logic [7:0] saw_n;
  logic tpush, rpush, tpop, dma_n, wr_reg, irq_upd;
  logic [RW-1:0] wr_ix;
  logic [15:0] saw_v;
  logic [1:0] kind_n;
  logic [31:0] v;

  always_comb begin
    tcsr_n = tcsr; rcsr_n = rcsr;
    trp_n = trp_q; twp_n = twp_q; tlv_n = tlv_q;
    rrp_n = rrp_q; rwp_n = rwp_q; rlv_n = rlv_q;
    saw_n = saw_q; saw_v = {saw_q, 8'h00};
    tpush = 1'b0; rpush = 1'b0; tpop = 1'b0;
    dma_n = 1'b0; wr_reg = 1'b0; wr_ix = '0; wr_reg_v = write_data_i;
    irq_upd = 1'b0; rd_n = '0; kind_n = K_REG; v = '0;
    unique case (req_type_i)
      REQ_READ: begin
        unique case (address_i)
          A_ID:  rd_n = id_q;
          A_CAP: rd_n = cap_q;
          A_TPTR: rd_n = {16'(twp_q), 16'(trp_q)};
          A_RPTR: rd_n = {16'(rwp_q), 16'(rrp_q)};
          A_RDATA: begin
            irq_upd = 1'b1;
            if (rlv_q != '0) begin
              kind_n = K_RX;
              rrp_n = inc(rrp_q); rlv_n = rlv_q - LW'(1);
            end else begin
              rd_n = {16'h0, saw_v}; saw_n = saw_q + 8'd1;
            end
            rcsr_n = rcsr & ~M_RO;
            rcsr_n[B_FRF] = 32'(rlv_n) > {24'h0, rcr1[7:0]};
            rcsr_n[B_FWF] = rlv_n >= FULL;
          end
          default: begin
            if (32'(address_i[9:2]) < REG_WORDS) rd_n = regs_q[RW'(address_i[9:2])];
          end
        endcase
      end
      REQ_WRITE: begin
        unique case (address_i)
          A_ID, A_CAP: ;
          A_TDATA: begin
            irq_upd = 1'b1;
            if (tlv_q < FULL) begin
              tpush = 1'b1; twp_n = inc(twp_q); tlv_n = tlv_q + LW'(1);
            end
            tcsr_n = tcsr & ~M_RO;
            tcsr_n[B_FRF] = 32'(tlv_n) <= {24'h0, tcr1[7:0]};
            tcsr_n[B_FWF] = tlv_n == '0;
          end
          A_TCSR, A_RCSR: begin
            irq_upd = 1'b1;
            v = write_data_i;
            v[B_FR] = 1'b0; v[B_SR] = 1'b0;
            if (address_i == A_TCSR) begin
              v = (v & ~(M_W1C | M_RO)) | (tcsr & M_RO) | (tcsr & M_W1C & ~write_data_i);
              if (write_data_i[B_FR]) begin
                trp_n = '0; twp_n = '0; tlv_n = '0;
              end
              if (v[B_EN] && !tcsr[B_EN]) begin
                v[B_FRF] = 32'(tlv_n) <= {24'h0, tcr1[7:0]};
                v[B_FWF] = tlv_n == '0;
              end
              tcsr_n = v;
            end else begin
              v = (v & ~(M_W1C | M_RO)) | (rcsr & M_RO) | (rcsr & M_W1C & ~write_data_i);
              if (write_data_i[B_FR]) begin
                rrp_n = '0; rwp_n = '0; rlv_n = '0;
              end
              if (v[B_EN] && !rcsr[B_EN]) begin
                v[B_FRF] = 32'(rlv_n) > {24'h0, rcr1[7:0]};
                v[B_FWF] = rlv_n >= FULL;
              end
              rcsr_n = v;
            end
          end
          default: begin
            if (32'(address_i[9:2]) < REG_WORDS) begin
              wr_ix = RW'(address_i[9:2]);
              // Unaligned offsets onto the control words store the raw value.
              if (wr_ix == RW'(2)) tcsr_n = write_data_i;
              else if (wr_ix == RW'(34)) rcsr_n = write_data_i;
              else wr_reg = 1'b1;
            end
          end
        endcase
      end
      REQ_TX: begin
        if (tcsr[B_EN]) begin
          irq_upd = 1'b1;
          tcsr_n = tcsr;
          if (tlv_q != '0) begin
            tpop = 1'b1; kind_n = K_TX;
            trp_n = inc(trp_q); tlv_n = tlv_q - LW'(1);
          end else if (!tcsr[B_DMA]) begin
            tcsr_n[B_FEF] = 1'b1;
          end
          dma_n = tcsr[B_DMA] && (32'(tlv_n) <= {24'h0, tcr1[7:0]});
          tcsr_n = tcsr_n & ~M_RO;
          tcsr_n[B_FRF] = 32'(tlv_n) <= {24'h0, tcr1[7:0]};
          tcsr_n[B_FWF] = tlv_n == '0;
        end
      end
      REQ_RX: begin
        if (rcsr[B_EN]) begin
          irq_upd = 1'b1;
          if (rlv_q < FULL) begin
            rpush = 1'b1; saw_n = saw_q + 8'd1;
            rwp_n = inc(rwp_q); rlv_n = rlv_q + LW'(1);
          end
          rcsr_n = rcsr & ~M_RO;
          rcsr_n[B_FRF] = 32'(rlv_n) > {24'h0, rcr1[7:0]};
          rcsr_n[B_FWF] = rlv_n >= FULL;
          dma_n = rcsr[B_DMA] && (32'(rlv_n) > {24'h0, rcr1[7:0]});
        end
      end
      default: ;
    endcase
  end

  logic irq_n;
  assign irq_n = irq_upd ? (side_irq(tcsr_n) || side_irq(rcsr_n)) : irq_q;

  // FIFO memories: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && tpush) tx_mem[twp_q] <= write_data_i;
    if (cmd_i.exec && rpush) rx_mem[rwp_q] <= saw_v;
    txrd_q <= tx_mem[trp_q];
    rxrd_q <= rx_mem[rrp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_WORDS; i++) regs_q[i] <= '0;
      regs_q[2] <= TCSR_RESET;
      id_q <= ID_RESET; cap_q <= CAP_RESET;
      trp_q <= '0; twp_q <= '0; tlv_q <= '0;
      rrp_q <= '0; rwp_q <= '0; rlv_q <= '0;
      saw_q <= '0; irq_q <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_ID) id_q <= cfg_data_i;
        else if (cfg_idx_i == CFG_CAP) cap_q <= cfg_data_i;
      end
      if (cmd_i.exec) begin
        regs_q[2] <= tcsr_n; regs_q[34] <= rcsr_n;
        if (wr_reg) regs_q[wr_ix] <= wr_reg_v;
        trp_q <= trp_n; twp_q <= twp_n; tlv_q <= tlv_n;
        rrp_q <= rrp_n; rwp_q <= rwp_n; rlv_q <= rlv_n;
        saw_q <= saw_n; irq_q <= irq_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      kind_q <= kind_n; rd_q <= rd_n; dma_q <= dma_n;
      tv_q <= tpop; irq_rslt_q <= irq_n;
    end
    if (cmd_i.finish) begin
      read_data_o <= (kind_q == K_RX) ? {16'h0, rxrd_q} : rd_q;
      tx_word_o <= (kind_q == K_TX) ? txrd_q : '0;
      tx_word_valid_o <= tv_q;
      dma_request_o <= dma_q;
      irq_level_o <= irq_rslt_q;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_CLK(a_tlv, tlv_q <= FULL, "tx level beyond depth")
  `ASSERT_CLK(a_rlv, rlv_q <= FULL, "rx level beyond depth")
  `ASSERT_CLK(a_done, cmd_i.finish |=> done_o, "result strobe missing")
endmodule

>>> rtl/audio_serial_fifo_port_core.sv
// Top level of the audio serial FIFO port register block.
// One item (bus read, bus write, transmit tick, receive tick) is taken when
// start_i is high and busy_o is low; the finish step registers its single
// result word onto the result ports together with done_o, which is high for
// exactly the cycle in which the word is new, and the word is taken at the
// edge that ends it; the receiver cannot stall it. A new item waits out the
// finish step (busy_o high): the exec step updates FIFO state and launches
// the FIFO memory read, the finish step forms the result from the registered
// read data. No clearing pass follows reset; FIFO memories need no initialization.
module audio_serial_fifo_port_core #(
  parameter int FIFO_DEPTH = 128,
  parameter int REG_WORDS  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  address_i,
  input  logic [31:0] write_data_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        irq_level_o,
  output logic        dma_request_o,
  output logic        tx_word_valid_o,
  output logic [31:0] tx_word_o
);
  import asfp_pkg::*;
  asfp_cmd_t cmd;

  // Sequence each word through evaluate and finish.
  asfp_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .busy_o, .cmd_o(cmd)
  );

  // Hold all state and drive the result ports.
  asfp_dp #(.FIFO_DEPTH(FIFO_DEPTH), .REG_WORDS(REG_WORDS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_type_i, .address_i, .write_data_i, .done_o, .read_data_o,
    .irq_level_o, .dma_request_o, .tx_word_valid_o, .tx_word_o
  );
endmodule
